[rtl/assert_macros.svh]
// assertion macros included by keyframe_envelope_eval
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, cond, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/kfe_pkg.sv]
// ----------------------------------------------------------------------------
// kfe_pkg
// shared constants for the keyframe envelope evaluator
// ----------------------------------------------------------------------------
package kfe_pkg;
  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_EVAL = 1'b1;
  localparam logic [2:0] CRV_STEP   = 3'd0;
  localparam logic [2:0] CRV_LINEAR = 3'd1;
  localparam logic [2:0] CRV_SLOW   = 3'd2;
  localparam logic [2:0] CRV_FAST   = 3'd3;
  localparam logic [2:0] CRV_SMOOTH = 3'd4;
  localparam logic [0:0] REG_COUNT = 1'b0;
  localparam logic [0:0] REG_CHAN  = 1'b1;
  localparam int TDATA_IN_W = 200;
  localparam int TDATA_OUT_W = 136;
  // divider request between the control sequencer and the divider
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } kfe_div_req_t;
endpackage

[rtl/kfe_div.sv]
// ----------------------------------------------------------------------------
// kfe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kfe_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kfe_pkg::kfe_div_req_t req,
  output logic                  done,
  output logic [47:0]           quo,
  output logic [31:0]           rem
);
  logic [47:0] q_r, q_nxt;
  logic [32:0] r_r, r_nxt;
  logic [31:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] sh;

  // load on start, else one shift-subtract step
  always_comb begin
    q_nxt = q_r; r_nxt = r_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {r_r[31:0], q_r[47]};
    if (req.start) begin
      q_nxt = req.num; r_nxt = '0; cnt_nxt = 6'd48; busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[46:0], 1'b0};
      r_nxt = sh;
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r};
        q_nxt[0] = 1'b1;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt;
    if (req.start) d_r <= req.den;
  end

  assign done = done_r;
  assign quo = q_r;
  assign rem = r_r[31:0];
endmodule

[rtl/kfe_table.sv]
// ----------------------------------------------------------------------------
// kfe_table
// keyframe memories: time/curve and channel values, registered read
// ----------------------------------------------------------------------------
module kfe_table #(
  parameter int MAX_POINTS = 64,
  parameter int CHANNELS = 4,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [33:0]                wr_tc,
  input  logic [CHANNELS*32-1:0]     wr_val,
  input  logic [AW-1:0]              rd_addr,
  output logic [33:0]                rd_tc,
  output logic [CHANNELS*32-1:0]     rd_val
);
  logic [33:0]            tc_mem [MAX_POINTS];
  logic [CHANNELS*32-1:0] val_mem [MAX_POINTS];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tc_mem[wr_addr] <= wr_tc;
      val_mem[wr_addr] <= wr_val;
    end
    rd_tc <= tc_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end
endmodule

[rtl/kfe_ctrl.sv]
// ----------------------------------------------------------------------------
// kfe_ctrl
// sequencer: wrap, segment scan, fraction, shaping and interpolation
// ----------------------------------------------------------------------------
module kfe_ctrl #(
  parameter int MAX_POINTS = 64,
  parameter int CHANNELS = 4,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [30:0]           eval_time,
  input  logic [CW-1:0]         n,
  input  logic [2:0]            ch,
  output logic [AW-1:0]         rd_addr,
  input  logic [33:0]           rd_tc,
  input  logic [CHANNELS*32-1:0] rd_val,
  output kfe_pkg::kfe_div_req_t div_req,
  input  logic                  div_done,
  input  logic [47:0]           div_quo,
  input  logic [31:0]           div_rem,
  output logic                  busy,
  output logic                  done,
  output logic [127:0]          res,
  output logic [5:0]            seg,
  output logic                  fb
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RLAST = 4'd1, S_LAST = 4'd2, S_MOD = 4'd3,
    S_RD0 = 4'd4, S_CMP = 4'd5, S_FRAC = 4'd6, S_SH1 = 4'd7, S_SH2 = 4'd8,
    S_SH3 = 4'd9, S_LERP = 4'd10, S_MUL = 4'd11, S_ADD = 4'd12, S_CONST = 4'd13,
    S_CWAIT = 4'd14, S_OUT = 4'd15;

  logic [3:0]  st_r, st_nxt;
  logic [30:0] t_r, t0_r;
  logic [AW-1:0] i_r;
  logic [2:0]  cv_r;
  logic [CHANNELS*32-1:0] v0_r;
  logic [16:0] a_r, b_r;
  logic [33:0] p_r;
  logic [50:0] p3_r;
  logic [1:0]  c_r;
  logic [32:0] dif_r;
  logic signed [50:0] prod_r;
  logic [127:0] res_r;
  logic [5:0]  seg_r;
  logic        fb_r, done_r, ld_v0_r;
  logic [30:0] tt;
  logic signed [32:0] v0s, v1s;
  logic [50:0] mag;
  logic signed [32:0] q;
  logic [CW-1:0] nm1;
  logic        hit, at_end, adv;

  assign tt = rd_tc[33:3];
  assign nm1 = n - CW'(1);
  assign busy = st_r != S_IDLE;
  assign done = done_r;
  assign res = res_r; assign seg = seg_r; assign fb = fb_r;

  // segment compare: i_r is the end point of the segment on the read port
  assign hit = (t_r >= t0_r) && (t_r <= tt);
  assign at_end = 32'(i_r) >= 32'(nm1);
  assign adv = (st_r == S_CMP) && !ld_v0_r && !hit && !at_end;

  // memory read address, one ahead while scanning
  always_comb begin
    case (st_r)
      S_IDLE:           rd_addr = '0;
      S_RLAST, S_CONST: rd_addr = (n == CW'(1)) ? '0 : nm1[AW-1:0];
      default:          rd_addr = adv ? i_r + AW'(1) : i_r;
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    div_req = '0;
    case (st_r)
      S_IDLE:  if (start) st_nxt = (n == '0) ? S_OUT : (n == CW'(1)) ? S_CONST : S_RLAST;
      S_RLAST: st_nxt = S_LAST;
      S_LAST: begin
        if (tt == '0) st_nxt = S_CONST;
        else begin
          div_req.start = 1'b1;
          div_req.num = {17'd0, eval_time};
          div_req.den = {1'b0, tt};
          st_nxt = S_MOD;
        end
      end
      S_MOD:   if (div_done) st_nxt = S_RD0;
      S_RD0:   st_nxt = S_CMP;
      S_CMP: begin
        if (ld_v0_r) st_nxt = S_CMP;
        else if (hit) begin
          if (tt == t0_r) st_nxt = S_SH1;
          else begin
            div_req.start = 1'b1;
            div_req.num = {1'b0, t_r - t0_r, 16'd0};
            div_req.den = {1'b0, tt - t0_r};
            st_nxt = S_FRAC;
          end
        end else if (at_end) st_nxt = S_CONST;
      end
      S_FRAC:  if (div_done) st_nxt = S_SH1;
      S_SH1:   st_nxt = S_SH2;
      S_SH2:   st_nxt = S_SH3;
      S_SH3:   st_nxt = S_LERP;
      S_LERP:  st_nxt = S_MUL;
      S_MUL:   st_nxt = S_ADD;
      S_ADD:   st_nxt = (c_r == 2'd3) ? S_OUT : S_LERP;
      S_CONST: st_nxt = S_CWAIT;
      S_CWAIT: st_nxt = S_OUT;
      S_OUT:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign v0s = 33'(signed'(v0_r[c_r*32 +: 32]));
  assign v1s = 33'(signed'(rd_val[c_r*32 +: 32]));
  assign mag = prod_r[50] ? 51'(-prod_r) : 51'(prod_r);
  always_comb begin
    if (prod_r[50]) q = -33'(signed'({1'b0, 32'((mag + 51'd65535) >> 16)}));
    else q = 33'(signed'({1'b0, 32'(mag >> 16)}));
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; done_r <= 1'b0; ld_v0_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= (st_r == S_OUT);
      case (st_r)
        S_IDLE: begin
          i_r <= '0; res_r <= '0; seg_r <= '0; fb_r <= 1'b1;
        end
        S_MOD: if (div_done) t_r <= div_rem[30:0];
        S_RD0: begin
          ld_v0_r <= 1'b1;
          i_r <= i_r + AW'(1);
        end
        S_CMP: begin
          if (ld_v0_r) begin
            t0_r <= tt; cv_r <= rd_tc[2:0]; v0_r <= rd_val; ld_v0_r <= 1'b0;
          end else if (hit) begin
            a_r <= '0;
          end else if (adv) begin
            t0_r <= tt; cv_r <= rd_tc[2:0]; v0_r <= rd_val;
            i_r <= i_r + AW'(1);
          end
        end
        S_FRAC: if (div_done) a_r <= div_quo[16:0];
        S_SH1: begin
          b_r <= (cv_r == kfe_pkg::CRV_FAST) ? 17'd65536 - a_r : a_r;
          p_r <= ((cv_r == kfe_pkg::CRV_FAST) ? 34'(17'd65536 - a_r) : 34'(a_r)) *
                 ((cv_r == kfe_pkg::CRV_FAST) ? 34'(17'd65536 - a_r) : 34'(a_r));
        end
        S_SH2: p3_r <= 51'(p_r) * 51'(b_r);
        S_SH3: begin
          case (cv_r)
            kfe_pkg::CRV_STEP:   a_r <= '0;
            kfe_pkg::CRV_SLOW:   a_r <= 17'(p3_r >> 32);
            kfe_pkg::CRV_FAST:   a_r <= 17'd65536 - 17'(p3_r >> 32);
            kfe_pkg::CRV_SMOOTH:
              a_r <= 17'((({17'd0, 3'd3 * p_r} << 16) - {p3_r[49:0], 1'b0}) >> 32);
            default:             a_r <= a_r;
          endcase
          c_r <= '0;
          seg_r <= 6'(i_r - AW'(1));
          fb_r <= 1'b0;
        end
        S_LERP: dif_r <= 33'(v1s - v0s);
        S_MUL:  prod_r <= 51'(signed'(dif_r)) * 51'(signed'({1'b0, a_r}));
        S_ADD: begin
          if ({1'b0, c_r} < ch && 32'(c_r) < 32'(CHANNELS))
            res_r[c_r*32 +: 32] <= 32'(v0s + q);
          c_r <= c_r + 2'd1;
        end
        S_CONST: begin
          i_r <= (n == CW'(1)) ? '0 : nm1[AW-1:0];
          seg_r <= '0; fb_r <= 1'b1;
        end
        S_CWAIT: res_r <= 128'(rd_val);
        default: ;
      endcase
    end
  end
endmodule

[rtl/keyframe_envelope_eval.sv]
// ----------------------------------------------------------------------------
// keyframe_envelope_eval
// keyframe table with curve-shaped interpolation of up to four channels
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | tuser: op; tdata: point_index, time, curve, values, eval_time
// out_    | out | tuser: fallback; tdata: result_0..3, segment
// cfg_    | in  | register index, write data
// a load is written at its accept edge; the next request may follow at once
// an evaluate runs up to two 48-step divider passes (wrap and fraction), the
// segment scan, the curve shaping and a lerp, multiply and add per channel
// with zero or one point, or a last time of zero, it skips divider and scan
// reset: synchronous rst_n clears control, point_count = 0, active_channels = 4
// one request at a time; the next input waits until the result is taken
`include "assert_macros.svh"
module keyframe_envelope_eval #(
  parameter int MAX_POINTS = 64,
  parameter int CHANNELS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op
  input  logic         in_tuser,
  // point_index, point_time, point_curve, point_value_0..3, eval_time, zero pad
  input  logic [kfe_pkg::TDATA_IN_W-1:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // fallback
  output logic         out_tuser,
  // result_0..3, segment, zero pad
  output logic [kfe_pkg::TDATA_OUT_W-1:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [6:0] pc_r;
  logic [2:0] ac_r;
  logic       ov_r;
  logic [kfe_pkg::TDATA_OUT_W-1:0] od_r;
  logic       ofb_r;
  logic [CW-1:0] n;
  logic [2:0] ch;
  logic acc, is_load, is_eval, start_r;
  logic busy, cdone, fb, ddone;
  logic [127:0] res;
  logic [5:0] seg;
  logic [AW-1:0] rd_addr;
  logic [33:0] rd_tc;
  logic [CHANNELS*32-1:0] rd_val, wr_val;
  kfe_pkg::kfe_div_req_t dreq;
  logic [47:0] dquo;
  logic [31:0] drem;

  assign in_tready = !busy && !ov_r && !start_r && !cdone;
  assign acc = in_tvalid && in_tready;
  assign is_load = acc && (in_tuser == kfe_pkg::OP_LOAD);
  assign is_eval = acc && (in_tuser == kfe_pkg::OP_EVAL);
  assign cfg_ready = 1'b1;
  assign n = (32'(pc_r) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pc_r);
  assign ch = (32'(ac_r) > 32'(CHANNELS)) ? 3'(CHANNELS) : ac_r;
  assign wr_val = in_tdata[40 +: CHANNELS*32];

  logic [30:0] et_r;
  // evaluate launches in the cycle after its accept
  always_ff @(posedge clk) begin
    if (!rst_n) start_r <= 1'b0;
    else start_r <= is_eval;
    if (is_eval) et_r <= in_tdata[198:168];
  end

  kfe_table #(.MAX_POINTS(MAX_POINTS), .CHANNELS(CHANNELS)) u_tab (
    .clk, .wr_en(is_load && 32'(in_tdata[5:0]) < 32'(MAX_POINTS)),
    .wr_addr(AW'(in_tdata[5:0])), .wr_tc({in_tdata[36:6], in_tdata[39:37]}),
    .wr_val, .rd_addr, .rd_tc, .rd_val);

  kfe_div u_div (.clk, .rst_n, .req(dreq), .done(ddone), .quo(dquo), .rem(drem));

  kfe_ctrl #(.MAX_POINTS(MAX_POINTS), .CHANNELS(CHANNELS)) u_ctrl (
    .clk, .rst_n, .start(start_r), .eval_time(et_r), .n, .ch, .rd_addr, .rd_tc, .rd_val,
    .div_req(dreq), .div_done(ddone), .div_quo(dquo), .div_rem(drem),
    .busy, .done(cdone), .res, .seg, .fb);

  // config registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; ac_r <= 3'd4; ov_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == kfe_pkg::REG_COUNT) pc_r <= cfg_data[6:0];
      if (cfg_valid && cfg_index == kfe_pkg::REG_CHAN) ac_r <= cfg_data[2:0];
      if (cdone) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (cdone) begin
      od_r <= {2'b00, seg, res};
      ofb_r <= fb;
    end
  end
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ofb_r;

  `ASSERT_IMPL(a_no_accept_busy, !(acc && busy), "input accepted while busy")
  `ASSERT_NEXT(a_done_valid, cdone, out_tvalid, "result lost")
  `ASSERT_IMPL(a_no_done_pending, !(cdone && ov_r), "result overwritten")
endmodule
